// ===== design/mjm_pkg.sv =====
package mjm_pkg;

  localparam int TIMEOUT_W   = 31;
  localparam int DIST_CFG_W  = 23;
  localparam int ATTEMPT_W   = 8;
  localparam int TICK_W      = 32;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 31;
  localparam int OP_W        = 2;
  localparam int STATUS_W    = 2;
  localparam int OUT_TDATA_W = 8;

  localparam logic [CFG_IDX_W-1:0] CFG_INIT_STEP_TIMEOUT = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_STEP_TIMEOUT      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_STEP_DISTANCE = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_RECOVERY_TIMEOUT  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_RECOVERY_DISTANCE = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_RECOVERY_ATTEMPTS = 3'd5;

  localparam logic [OP_W-1:0] OP_UPDATE  = 2'd0;
  localparam logic [OP_W-1:0] OP_START   = 2'd1;
  localparam logic [OP_W-1:0] OP_RECOVER = 2'd2;

  localparam logic [ATTEMPT_W-1:0] ATTEMPT_MAX = 8'd255;

  typedef enum logic [STATUS_W-1:0] {
    MODE_NOMINAL  = 2'd0,
    MODE_STUCK    = 2'd1,
    MODE_RECOVERY = 2'd2,
    MODE_FATAL    = 2'd3
  } mode_e;

  typedef struct packed {
    logic [TIMEOUT_W-1:0]  init_step_timeout;
    logic [TIMEOUT_W-1:0]  step_timeout;
    logic [DIST_CFG_W-1:0] min_step_distance;
    logic [TIMEOUT_W-1:0]  recovery_timeout;
    logic [DIST_CFG_W-1:0] recovery_distance;
    logic [ATTEMPT_W-1:0]  recovery_attempts;
  } cfg_t;

endpackage

// ===== design/mjm_cfg_regs.sv =====
module mjm_cfg_regs (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [mjm_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [mjm_pkg::CFG_DATA_W-1:0]   cfg_wdata_i,
  output mjm_pkg::cfg_t                    cfg_o
);
  import mjm_pkg::*;

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_INIT_STEP_TIMEOUT: cfg_d.init_step_timeout = cfg_wdata_i[TIMEOUT_W-1:0];
        CFG_STEP_TIMEOUT:      cfg_d.step_timeout      = cfg_wdata_i[TIMEOUT_W-1:0];
        CFG_MIN_STEP_DISTANCE: cfg_d.min_step_distance = cfg_wdata_i[DIST_CFG_W-1:0];
        CFG_RECOVERY_TIMEOUT:  cfg_d.recovery_timeout  = cfg_wdata_i[TIMEOUT_W-1:0];
        CFG_RECOVERY_DISTANCE: cfg_d.recovery_distance = cfg_wdata_i[DIST_CFG_W-1:0];
        CFG_RECOVERY_ATTEMPTS: cfg_d.recovery_attempts = cfg_wdata_i[ATTEMPT_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== design/mjm_core.sv =====
module mjm_core #(
  parameter int POSITION_WIDTH = 24
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           fire_i,
  input  logic [mjm_pkg::OP_W-1:0]       op_i,
  input  logic [POSITION_WIDTH-1:0]      position_i,
  input  logic [POSITION_WIDTH-1:0]      target_i,
  input  logic [mjm_pkg::TICK_W-1:0]     now_ms_i,
  input  mjm_pkg::cfg_t                  cfg_i,
  output mjm_pkg::mode_e                 mode_o
);
  import mjm_pkg::*;

  localparam int DW = POSITION_WIDTH + 1;
  localparam int SW = ((DW > DIST_CFG_W) ? DW : DIST_CFG_W) + 1;

  mode_e                     mode_q, mode_d;
  logic [ATTEMPT_W-1:0]      attempt_q, attempt_d, attempt_inc;
  logic [TICK_W-1:0]         deadline_q, deadline_d, deadline_gap;
  logic [DW-1:0]             last_q, last_d;
  logic [POSITION_WIDTH-1:0] goal_q, goal_d;

  logic [POSITION_WIDTH-1:0] ref_pos;
  logic [DW-1:0]             diff, ndiff, rem;
  logic [SW-1:0]             rem_plus_min, last_plus_rec;
  logic                      passed, progress, moved_away;

  // distance to the goal, new goal on a start
  assign ref_pos = (op_i == OP_START) ? target_i : goal_q;
  assign diff    = {ref_pos[POSITION_WIDTH-1], ref_pos}
                 - {position_i[POSITION_WIDTH-1], position_i};
  assign ndiff   = {position_i[POSITION_WIDTH-1], position_i}
                 - {ref_pos[POSITION_WIDTH-1], ref_pos};
  assign rem     = diff[DW-1] ? ndiff : diff;

  assign rem_plus_min  = SW'(rem) + SW'(cfg_i.min_step_distance);
  assign last_plus_rec = SW'(last_q) + SW'(cfg_i.recovery_distance);
  assign progress      = rem_plus_min < SW'(last_q);
  assign moved_away    = SW'(rem) > last_plus_rec;

  // wraparound deadline check
  assign deadline_gap = deadline_q - now_ms_i;
  assign passed       = deadline_gap[TICK_W-1];
  assign attempt_inc  = (attempt_q == ATTEMPT_MAX) ? attempt_q : attempt_q + 1'b1;

  always_comb begin
    mode_d     = mode_q;
    attempt_d  = attempt_q;
    deadline_d = deadline_q;
    last_d     = last_q;
    goal_d     = goal_q;
    case (op_i)
      OP_START: begin
        mode_d     = MODE_NOMINAL;
        attempt_d  = '0;
        deadline_d = now_ms_i + {1'b0, cfg_i.init_step_timeout};
        goal_d     = target_i;
        last_d     = rem;
      end
      OP_RECOVER: begin
        if (mode_q != MODE_FATAL) begin
          mode_d     = MODE_RECOVERY;
          deadline_d = now_ms_i + {1'b0, cfg_i.recovery_timeout};
        end
      end
      OP_UPDATE: begin
        if (mode_q == MODE_NOMINAL) begin
          if (progress) begin
            last_d     = rem;
            deadline_d = now_ms_i + {1'b0, cfg_i.step_timeout};
          end else if (passed) begin
            attempt_d = attempt_inc;
            mode_d    = (attempt_inc <= cfg_i.recovery_attempts) ? MODE_STUCK : MODE_FATAL;
          end
        end else if (mode_q == MODE_RECOVERY) begin
          if (moved_away) begin
            mode_d     = MODE_NOMINAL;
            last_d     = rem;
            deadline_d = now_ms_i + {1'b0, cfg_i.init_step_timeout};
          end else if (passed) begin
            mode_d = MODE_FATAL;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q     <= MODE_NOMINAL;
      attempt_q  <= '0;
      deadline_q <= '0;
      last_q     <= '0;
      goal_q     <= '0;
    end else if (fire_i) begin
      mode_q     <= mode_d;
      attempt_q  <= attempt_d;
      deadline_q <= deadline_d;
      last_q     <= last_d;
      goal_q     <= goal_d;
    end
  end

  assign mode_o = mode_d;

endmodule

// ===== design/motor_jam_monitor.sv =====
// motor_jam_monitor: jam watchdog for a positioning motor
//
// input stream: one beat per event. s_axis_tuser carries the op (update,
// start, start recovery); s_axis_tdata carries position, target and the
// millisecond tick. output stream: one beat per input beat, m_axis_tdata
// carries the mode after that event (nominal, stuck, recovery, fatal).
// configuration: cfg_we_i writes cfg_wdata_i into register cfg_idx_i;
// write only while no beat is in flight.
//
// pipeline: an accepted beat lands in an input register, is evaluated against
// the watchdog state and its result is captured in the output register once
// the output register can advance. throughput: one beat per cycle when the
// output is not stalled; each beat moves on while the next is accepted.
// when m_axis_tready is low the output register holds its beat, the input
// register fills, and s_axis_tready drops only when both are full.
// reset clears the config registers to zero, the mode to nominal and all
// watchdog state to zero; no beats are held after reset.
module motor_jam_monitor #(
  parameter int POSITION_WIDTH = 24
) (
  input  logic                                     clk_i,
  input  logic                                     rst_ni,
  input  logic                                     s_axis_tvalid,
  output logic                                     s_axis_tready,
  // position, target, now_ms
  input  logic [((2*POSITION_WIDTH+32+7)/8)*8-1:0] s_axis_tdata,
  // op
  input  logic [mjm_pkg::OP_W-1:0]                 s_axis_tuser,
  output logic                                     m_axis_tvalid,
  input  logic                                     m_axis_tready,
  // status
  output logic [mjm_pkg::OUT_TDATA_W-1:0]          m_axis_tdata,
  input  logic                                     cfg_we_i,
  input  logic [mjm_pkg::CFG_IDX_W-1:0]            cfg_idx_i,
  input  logic [mjm_pkg::CFG_DATA_W-1:0]           cfg_wdata_i
);
  import mjm_pkg::*;

  localparam int PW = POSITION_WIDTH;

  cfg_t            cfg;
  mode_e           mode_next;
  logic            in_valid_q, out_valid_q, advance, fire;
  logic [OP_W-1:0] op_q;
  logic [PW-1:0]   pos_q, tgt_q;
  logic [TICK_W-1:0] now_q;
  logic [STATUS_W-1:0] status_q;

  assign advance       = !out_valid_q || m_axis_tready;
  assign fire          = in_valid_q && advance;
  assign s_axis_tready = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s_axis_tready) begin
        in_valid_q <= s_axis_tvalid;
      end
      if (advance) begin
        out_valid_q <= in_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      op_q  <= s_axis_tuser;
      pos_q <= s_axis_tdata[PW-1:0];
      tgt_q <= s_axis_tdata[2*PW-1:PW];
      now_q <= s_axis_tdata[2*PW+TICK_W-1:2*PW];
    end
    if (fire) begin
      status_q <= mode_next;
    end
  end

  mjm_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  mjm_core #(
    .POSITION_WIDTH (PW)
  ) u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .fire_i     (fire),
    .op_i       (op_q),
    .position_i (pos_q),
    .target_i   (tgt_q),
    .now_ms_i   (now_q),
    .cfg_i      (cfg),
    .mode_o     (mode_next)
  );

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{(OUT_TDATA_W-STATUS_W){1'b0}}, status_q};

endmodule

// ===== design/mjm_checker.sv =====
module mjm_checker (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              s_axis_tready,
  input logic                              m_axis_tvalid,
  input logic                              m_axis_tready,
  input logic [mjm_pkg::OUT_TDATA_W-1:0]   m_axis_tdata
);
  import mjm_pkg::*;

  // a stalled output beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("output beat dropped or changed under stall");

  // input side only backs up when the output register is full and stalled
  a_ready_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
    else $error("input stalled without output backpressure");

  // status padding stays zero
  a_pad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[OUT_TDATA_W-1:STATUS_W] == '0)
    else $error("nonzero padding in output beat");

endmodule

bind motor_jam_monitor mjm_checker u_mjm_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
